>>> src/mcpet_pkg.sv
package mcpet_pkg;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_SET     = 2'd1;
    localparam logic [1:0] OP_CONSUME = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic [1:0] KIND_EVENT     = 2'd0;
    localparam logic [1:0] KIND_SUMMARY   = 2'd1;
    localparam logic [1:0] KIND_DELIVERED = 2'd2;
    localparam logic [1:0] KIND_IGNORED   = 2'd3;

    localparam logic [15:0] WAIT_RESET   = 16'd60000;
    localparam logic [31:0] OFF_INTERVAL = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_FIRE,
        ST_SUMMARY,
        ST_CONSUME,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the input word
        logic set_chan;   // program one channel
        logic scan_start; // clear the running minimum
        logic scan_step;  // compare one channel
        logic fire;       // advance the winner, post an event if room
        logic consume;    // retire one pending event, build the answer
        logic summary;    // build the summary word
        logic out_take;   // output word was taken
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;  // last channel compared this cycle
        logic due;        // a valid deadline is at or before now
        logic out_full;   // output register holds a word
    } stat_t;

endpackage

>>> src/mcpet_ctrl.sv
module mcpet_ctrl #(
    parameter int MAX_FIRES = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        in_op,
    input  logic              out_ready,
    input  mcpet_pkg::stat_t  stat,
    output mcpet_pkg::cmd_t   cmd
);
    import mcpet_pkg::*;

    localparam int FW = $clog2(MAX_FIRES + 1);

    state_t          state_reg, state_next;
    logic [FW-1:0]   fires_reg, fires_next;

    // State and firing counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fires_reg <= '0;
        end else begin
            state_reg <= state_next;
            fires_reg <= fires_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next   = state_reg;
        fires_next   = fires_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        cmd.out_take = stat.out_full && out_ready;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    fires_next = '0;
                    case (in_op)
                        OP_TICK: begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        OP_SET:     state_next = ST_IDLE;
                        OP_CONSUME: state_next = ST_CONSUME;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (stat.due && fires_reg < FW'(MAX_FIRES)) state_next = ST_FIRE;
                else state_next = ST_SUMMARY;
            end
            ST_FIRE: begin
                // Wait for room in the output register before posting.
                if (!stat.out_full || cmd.out_take) begin
                    cmd.fire       = 1'b1;
                    cmd.scan_start = 1'b1;
                    fires_next     = fires_reg + 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SUMMARY: begin
                if (!stat.out_full || cmd.out_take) begin
                    cmd.summary = 1'b1;
                    state_next  = ST_OUT;
                end
            end
            ST_CONSUME: begin
                cmd.consume = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (!stat.out_full) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

>>> src/mcpet_dp.sv
module mcpet_dp #(
    parameter int CHANNELS         = 8,
    parameter int DEFAULT_CAPACITY = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  mcpet_pkg::cmd_t   cmd,
    output mcpet_pkg::stat_t  stat,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata,
    input  logic [2:0]        in_channel,
    input  logic [63:0]       in_now,
    input  logic              in_enable,
    input  logic [31:0]       in_interval,
    input  logic [15:0]       in_capacity,
    output logic [1:0]        out_kind,
    output logic [2:0]        out_channel,
    output logic [63:0]       out_tick,
    output logic [15:0]       out_wait,
    output logic              out_last
);
    import mcpet_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic        en_reg   [CHANNELS];
    logic [31:0] iv_reg   [CHANNELS];
    logic [15:0] cap_reg  [CHANNELS];
    logic [63:0] ref_reg  [CHANNELS];
    logic        dv_reg   [CHANNELS];
    logic [15:0] pend_reg [CHANNELS];
    logic [15:0] maxw_reg;

    logic [2:0]  ch_reg;
    logic [63:0] now_reg;
    logic        en_in_reg;
    logic [31:0] iv_in_reg;
    logic [15:0] cap_in_reg;

    logic [CW-1:0] idx_reg;
    logic          bvalid_reg;
    logic [CW-1:0] best_reg;
    logic [63:0]   bref_reg;

    logic        full_reg;
    logic [1:0]  kind_reg;
    logic [2:0]  och_reg;
    logic [63:0] tick_reg;
    logic [15:0] wait_reg;
    logic        last_reg;

    logic          ch_ok;
    logic [CW-1:0] ch_idx;
    logic          take;
    logic [63:0]   diff;

    assign ch_ok  = 32'(ch_reg) < CHANNELS;
    assign ch_idx = CW'(ch_reg);
    assign take   = dv_reg[idx_reg] && (!bvalid_reg || ref_reg[idx_reg] < bref_reg);
    assign diff   = bref_reg - now_reg;

    assign stat.scan_done = 32'(idx_reg) == CHANNELS - 1;
    assign stat.due       = bvalid_reg && bref_reg <= now_reg;
    assign stat.out_full  = full_reg;

    // Input word capture and the max_wait register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            maxw_reg <= WAIT_RESET;
        end else if (cfg_we) begin
            maxw_reg <= cfg_wdata;
        end
        if (cmd.load) begin
            ch_reg     <= in_channel;
            now_reg    <= in_now;
            en_in_reg  <= in_enable;
            iv_in_reg  <= in_interval;
            cap_in_reg <= in_capacity;
        end
    end

    // Earliest-deadline scan, one channel a cycle.
    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            idx_reg    <= '0;
            bvalid_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            if (!stat.scan_done) idx_reg <= idx_reg + 1'b1;
            if (take) begin
                bvalid_reg <= 1'b1;
                best_reg   <= idx_reg;
                bref_reg   <= ref_reg[idx_reg];
            end
        end
    end

    // Channel state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                en_reg[i]   <= 1'b0;
                iv_reg[i]   <= '0;
                cap_reg[i]  <= 16'(DEFAULT_CAPACITY);
                ref_reg[i]  <= '0;
                dv_reg[i]   <= 1'b0;
                pend_reg[i] <= '0;
            end
        end else begin
            // A set_channel word is applied the cycle after capture.
            if (cmd.set_chan && ch_ok) begin
                en_reg[ch_idx]   <= en_in_reg;
                iv_reg[ch_idx]   <= iv_in_reg;
                cap_reg[ch_idx]  <= cap_in_reg;
                pend_reg[ch_idx] <= '0;
                if (en_in_reg && iv_in_reg != OFF_INTERVAL) begin
                    ref_reg[ch_idx] <= now_reg + 64'(iv_in_reg);
                    dv_reg[ch_idx]  <= 1'b1;
                end else begin
                    dv_reg[ch_idx] <= 1'b0;
                end
            end
            if (cmd.fire) begin
                ref_reg[best_reg] <= bref_reg + 64'(iv_reg[best_reg]);
                if ((cap_reg[best_reg] == '0 || pend_reg[best_reg] < cap_reg[best_reg])
                        && pend_reg[best_reg] != 16'hFFFF)
                    pend_reg[best_reg] <= pend_reg[best_reg] + 1'b1;
            end
            if (cmd.consume && ch_ok && pend_reg[ch_idx] != '0)
                pend_reg[ch_idx] <= pend_reg[ch_idx] - 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else begin
            if (cmd.out_take) full_reg <= 1'b0;
            if (cmd.fire) begin
                if (cap_reg[best_reg] == '0 || pend_reg[best_reg] < cap_reg[best_reg]) begin
                    full_reg <= 1'b1;
                    kind_reg <= KIND_EVENT;
                    och_reg  <= 3'(best_reg);
                    tick_reg <= bref_reg;
                    wait_reg <= '0;
                    last_reg <= 1'b0;
                end
            end
            if (cmd.summary) begin
                full_reg <= 1'b1;
                kind_reg <= KIND_SUMMARY;
                och_reg  <= '0;
                tick_reg <= '0;
                last_reg <= 1'b1;
                if (!bvalid_reg) wait_reg <= maxw_reg;
                else if (stat.due) wait_reg <= '0;
                else if (diff > 64'(maxw_reg)) wait_reg <= maxw_reg;
                else wait_reg <= diff[15:0];
            end
            if (cmd.consume) begin
                full_reg <= 1'b1;
                kind_reg <= (ch_ok && en_reg[ch_idx] && iv_reg[ch_idx] != OFF_INTERVAL)
                            ? KIND_DELIVERED : KIND_IGNORED;
                och_reg  <= ch_reg;
                tick_reg <= '0;
                wait_reg <= '0;
                last_reg <= 1'b1;
            end
        end
    end

    assign out_kind    = kind_reg;
    assign out_channel = och_reg;
    assign out_tick    = tick_reg;
    assign out_wait    = wait_reg;
    assign out_last    = last_reg;
endmodule

>>> src/multi_channel_periodic_event_timer.sv
// Periodic timer bank with earliest-deadline firing. A set_channel word gives
// no result; a consume word gives one result. A tick word scans all channels
// one per cycle for the earliest deadline, fires it while it is due (at most
// MAX_FIRES times), then builds a summary. No new word is accepted until the
// last result of the current word has been taken. Every result word carries
// last on the final word of its input word.
// max_wait may be written only while idle.
module multi_channel_periodic_event_timer #(
    parameter int CHANNELS         = 8,
    parameter int MAX_FIRES        = 32,
    parameter int DEFAULT_CAPACITY = 1
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [2:0]  s_channel,
    input  logic [63:0] s_now_time,
    input  logic        s_enable,
    input  logic [31:0] s_interval,
    input  logic [15:0] s_capacity,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [2:0]  m_event_channel,
    output logic [63:0] m_event_tick,
    output logic [15:0] m_wait_time,
    output logic        m_last
);
    import mcpet_pkg::*;

    cmd_t  cmd, cmd_c;
    stat_t stat;
    logic  set_reg;
    logic  s_ready_c;

    // A set_channel word is applied in the cycle after capture.
    always_ff @(posedge aclk) begin
        if (!aresetn) set_reg <= 1'b0;
        else set_reg <= s_valid && s_ready && s_operation == OP_SET;
    end

    always_comb begin
        cmd          = cmd_c;
        cmd.set_chan = set_reg;
    end

    mcpet_ctrl #(.MAX_FIRES(MAX_FIRES)) u_ctrl (
        .aclk, .aresetn,
        .in_valid (s_valid && !set_reg),
        .in_ready (s_ready_c),
        .in_op    (s_operation),
        .out_ready(m_ready),
        .stat,
        .cmd      (cmd_c)
    );

    assign s_ready = s_ready_c && !set_reg;

    mcpet_dp #(.CHANNELS(CHANNELS), .DEFAULT_CAPACITY(DEFAULT_CAPACITY)) u_dp (
        .aclk, .aresetn, .cmd, .stat, .cfg_we, .cfg_wdata,
        .in_channel (s_channel),
        .in_now     (s_now_time),
        .in_enable  (s_enable),
        .in_interval(s_interval),
        .in_capacity(s_capacity),
        .out_kind   (m_kind),
        .out_channel(m_event_channel),
        .out_tick   (m_event_tick),
        .out_wait   (m_wait_time),
        .out_last   (m_last)
    );

    assign m_valid = stat.out_full;

    // No new word while a result is pending.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !m_valid) else $error("accept while busy");
    // Only result words ending in last or events exist.
    a_kind_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_EVENT) |-> !m_last) else $error("event marked last");
    a_nonevent_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != KIND_EVENT) |-> m_last) else $error("missing last");
endmodule
